[hdl/anbf_pkg.sv]
// Shared types and constants for the Annex B NAL boundary finder.
// Used by anbf_out_fifo and annexb_nal_boundary_finder; no dependencies.
package anbf_pkg;

  localparam int POS_W      = 32;  // byte position width, 16..32
  localparam int OUT_W      = 32;  // width of offset/length fields
  localparam int LONG_CODE  = 4;
  localparam int SHORT_CODE = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,  // waiting for the leading start code
    PH_UNIT = 2'd1,  // inside a unit
    PH_FAIL = 2'd2   // leading start code missing, wait for end
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_W-1:0] nal_offset;
    logic [OUT_W-1:0] nal_length;
    logic             last_nal;
    logic             no_start_error;
  } out_beat_t;

  // Up to two results produced by one input byte.
  typedef struct packed {
    logic [1:0] cnt;
    out_beat_t  item0;
    out_beat_t  item1;
  } push_t;

  function automatic logic [OUT_W-1:0] to_out(input pos_t p);
    return OUT_W'(p);
  endfunction

endpackage

[hdl/anbf_out_fifo.sv]
// Result queue: takes zero, one or two beats per cycle, hands out one while out_ready is high.
// Depends on anbf_pkg.
module anbf_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  anbf_pkg::push_t   push,
  output logic              room_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output anbf_pkg::out_beat_t out_data
);
  import anbf_pkg::*;

  out_beat_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  // room for the worst case of two pushes
  assign room_ok   = (count_r <= FIFO_CW'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + FIFO_CW'(push.cnt) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.item0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + FIFO_AW'(1)] <= push.item1;
    end
  end

endmodule

[hdl/annexb_nal_boundary_finder.sv]
// Top level of the Annex B NAL boundary finder: byte parser and result queue.
// Depends on anbf_pkg and anbf_out_fifo.
//
// Splits an H.264 Annex B byte stream into NAL units and reports, for each
// unit, the offset and length of its payload (start code excluded). One byte
// is taken per cycle while in_ready is high: in_ready depends only on the
// fill level of a four-beat result queue, which is kept able to absorb the
// two results a single byte can produce, so with out_ready held high the
// block sustains one byte per clock; the results of a byte are registered
// in the queue. The stream must open with 00 00 01 or 00 00 00 01; if not,
// the bytes are swallowed and one beat with no_start_error set goes out when
// last_byte arrives. A start code on the final byte yields the closed unit
// plus an empty final unit. After a last_byte beat all parser state returns
// to reset, so the next byte starts a new stream. Positions wrap at POS_W.
module annexb_nal_boundary_finder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  anbf_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output anbf_pkg::out_beat_t  out_data
);
  import anbf_pkg::*;

  pos_t        pos_r, pos_nxt;
  pos_t        start_r, start_nxt;
  logic [23:0] recent_r, recent_nxt;
  phase_t      phase_r, phase_nxt;
  push_t       push;
  logic        in_fire;

  // per-byte scratch
  pos_t        next_pos;
  pos_t        code_pos;
  logic        lead_done, lead_fail, sc_hit;
  logic [7:0]  b;
  logic        last;

  assign in_fire = in_valid && in_ready;
  assign b       = in_data.data_byte;
  assign last    = in_data.last_byte;

  always_comb begin
    next_pos   = pos_r + POS_W'(1);
    // long code when the zero before 00 00 lies inside the unit
    code_pos   = pos_r - ((recent_r[23:16] == 8'h00) ? POS_W'(LONG_CODE - 1)
                                                     : POS_W'(SHORT_CODE - 1));
    sc_hit     = (b == 8'h01) && (recent_r[15:0] == 16'h0000);
    lead_done  = 1'b0;
    lead_fail  = 1'b0;

    // leading start code check by position
    if (pos_r == POS_W'(0) || pos_r == POS_W'(1)) begin
      lead_fail = (b != 8'h00);
    end else if (pos_r == POS_W'(2)) begin
      lead_done = (b == 8'h01);
      lead_fail = (b != 8'h00) && (b != 8'h01);
    end else if (pos_r == POS_W'(SHORT_CODE)) begin
      lead_done = (b == 8'h01);
      lead_fail = (b != 8'h01);
    end else begin
      lead_fail = 1'b1;
    end

    pos_nxt    = pos_r;
    start_nxt  = start_r;
    recent_nxt = recent_r;
    phase_nxt  = phase_r;
    push       = '0;

    if (in_fire) begin
      pos_nxt = next_pos;
      case (phase_r)
        PH_LEAD: begin
          if (lead_done) begin
            start_nxt  = next_pos;
            recent_nxt = '1;
            phase_nxt  = PH_UNIT;
            if (last) begin
              push.cnt              = 2'd1;
              push.item0.nal_offset = to_out(next_pos);
              push.item0.last_nal   = 1'b1;
            end
          end else begin
            if (lead_fail) begin
              phase_nxt = PH_FAIL;
            end
            if (last) begin
              push.cnt                  = 2'd1;
              push.item0.last_nal       = 1'b1;
              push.item0.no_start_error = 1'b1;
            end
          end
        end
        PH_UNIT: begin
          if (sc_hit) begin
            push.cnt              = 2'd1;
            push.item0.nal_offset = to_out(start_r);
            push.item0.nal_length = to_out(code_pos - start_r);
            start_nxt             = next_pos;
            recent_nxt            = '1;
            if (last) begin
              // trailing start code: empty final unit
              push.cnt              = 2'd2;
              push.item1.nal_offset = to_out(next_pos);
              push.item1.last_nal   = 1'b1;
            end
          end else begin
            recent_nxt = {recent_r[15:0], b};
            if (last) begin
              push.cnt              = 2'd1;
              push.item0.nal_offset = to_out(start_r);
              push.item0.nal_length = to_out(next_pos - start_r);
              push.item0.last_nal   = 1'b1;
            end
          end
        end
        default: begin
          if (last) begin
            push.cnt                  = 2'd1;
            push.item0.last_nal       = 1'b1;
            push.item0.no_start_error = 1'b1;
          end
        end
      endcase

      // end of stream: back to reset values
      if (last) begin
        pos_nxt    = '0;
        start_nxt  = '0;
        recent_nxt = '1;
        phase_nxt  = PH_LEAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      start_r  <= '0;
      recent_r <= '1;
      phase_r  <= PH_LEAD;
    end else begin
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      recent_r <= recent_nxt;
      phase_r  <= phase_nxt;
    end
  end

  anbf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room_ok   (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // a last_byte beat always leaves the parser at stream start
  a_eos_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_byte |=> phase_r == PH_LEAD && pos_r == '0)
    else $error("parser not reset after last byte");

  // two results only for a start code on the final byte, second one final
  a_dual_push: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> phase_r == PH_UNIT && in_data.last_byte &&
                         push.item1.last_nal && !push.item0.last_nal)
    else $error("bad dual result");

  // error beat is always the final, empty one
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 && push.item0.no_start_error |->
      push.item0.last_nal && push.item0.nal_length == '0 &&
      push.item0.nal_offset == '0)
    else $error("malformed error result");
`endif

endmodule

[verif/anbf_result_checker.sv]
// Checker for annexb_nal_boundary_finder: tracks the byte stream, predicts NAL unit results.
// Depends on anbf_pkg (beat structs, phase_t, start code lengths).
module anbf_result_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  anbf_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  anbf_pkg::out_beat_t out_data,
  output int                  mismatches,
  output int                  units_waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import anbf_pkg::*;

  pos_t        cur_pos;
  pos_t        unit_start;
  logic [23:0] last3;      // oldest byte on top
  phase_t      phase;
  out_beat_t   nal_expect[$];

  function void restart_stream();
    cur_pos    = '0;
    unit_start = '0;
    last3      = 24'hFFFFFF;
    phase      = PH_LEAD;
  endfunction

  function void queue_unit(input pos_t off, input pos_t len, input logic fin,
                           input logic err);
    out_beat_t u;
    u.nal_offset     = OUT_W'(off);
    u.nal_length     = OUT_W'(len);
    u.last_nal       = fin;
    u.no_start_error = err;
    nal_expect.push_back(u);
  endfunction

  function void split_byte(input logic [7:0] b, input logic fin);
    pos_t nxt;
    pos_t code_at;
    logic lead_ok;
    logic lead_bad;
    nxt      = cur_pos + pos_t'(1);
    lead_ok  = 1'b0;
    lead_bad = 1'b0;
    case (phase)
      PH_LEAD: begin
        if (cur_pos < pos_t'(SHORT_CODE - 1)) begin
          lead_bad = (b != 8'h00);
        end else if (cur_pos == pos_t'(SHORT_CODE - 1)) begin
          lead_ok  = (b == 8'h01);
          lead_bad = (b != 8'h00) && (b != 8'h01);
        end else if (cur_pos == pos_t'(SHORT_CODE)) begin
          lead_ok  = (b == 8'h01);
          lead_bad = !lead_ok;
        end else begin
          lead_bad = 1'b1;
        end
        if (lead_ok && fin) begin
          queue_unit(nxt, '0, 1'b1, 1'b0);
          restart_stream();
        end else if (lead_ok) begin
          unit_start = nxt;
          last3      = 24'hFFFFFF;
          phase      = PH_UNIT;
          cur_pos    = nxt;
        end else if (fin) begin
          queue_unit('0, '0, 1'b1, 1'b1);
          restart_stream();
        end else begin
          if (lead_bad) phase = PH_FAIL;
          cur_pos = nxt;
        end
      end
      PH_UNIT: begin
        if (b == 8'h01 && last3[15:0] == 16'h0000) begin
          // zero ahead of 00 00 01 still inside the unit -> long code
          if (last3[23:16] == 8'h00) code_at = cur_pos - pos_t'(LONG_CODE - 1);
          else code_at = cur_pos - pos_t'(SHORT_CODE - 1);
          queue_unit(unit_start, code_at - unit_start, 1'b0, 1'b0);
          unit_start = nxt;
          last3      = 24'hFFFFFF;
          if (fin) begin
            queue_unit(nxt, '0, 1'b1, 1'b0);
            restart_stream();
          end else begin
            cur_pos = nxt;
          end
        end else begin
          last3 = {last3[15:0], b};
          if (fin) begin
            queue_unit(unit_start, nxt - unit_start, 1'b1, 1'b0);
            restart_stream();
          end else begin
            cur_pos = nxt;
          end
        end
      end
      default: begin
        if (fin) begin
          queue_unit('0, '0, 1'b1, 1'b1);
          restart_stream();
        end else begin
          cur_pos = nxt;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    out_beat_t want;
    if (!rst_n) begin
      restart_stream();
      nal_expect.delete();
      mismatches = 0;
    end else begin
      if (in_valid && in_ready) split_byte(in_data.data_byte, in_data.last_byte);
      if (out_valid && out_ready) begin
        if (nal_expect.size() == 0) begin
          $error("result with none pending: nal_offset %0d nal_length %0d",
                 out_data.nal_offset, out_data.nal_length);
          mismatches++;
        end else begin
          want = nal_expect.pop_front();
          if (out_data.nal_offset !== want.nal_offset) begin
            $error("nal_offset: expected %0d, got %0d", want.nal_offset, out_data.nal_offset);
            mismatches++;
          end
          if (out_data.nal_length !== want.nal_length) begin
            $error("nal_length: expected %0d, got %0d", want.nal_length, out_data.nal_length);
            mismatches++;
          end
          if (out_data.last_nal !== want.last_nal) begin
            $error("last_nal: expected %0b, got %0b", want.last_nal, out_data.last_nal);
            mismatches++;
          end
          if (out_data.no_start_error !== want.no_start_error) begin
            $error("no_start_error: expected %0b, got %0b",
                   want.no_start_error, out_data.no_start_error);
            mismatches++;
          end
        end
      end
    end
    units_waiting <= nal_expect.size();
  end

endmodule

[verif/annexb_nal_boundary_finder_tb.sv]
// Top of the annexb_nal_boundary_finder testbench: clock, reset, byte streams, verdict.
// Depends on anbf_pkg, annexb_nal_boundary_finder and anbf_result_checker.
module annexb_nal_boundary_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import anbf_pkg::*;

  localparam int RANDOM_BYTES  = 950;
  localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
  localparam int SETTLE_CYCLES = 6;     // pause after the last predicted unit is out
  localparam int QUIET_LIMIT   = 2000;  // cycles with no beat on either side

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  int   mismatches;
  int   units_waiting;
  bit   long_hold;    // set by the sender; the receiver honors it once
  bit   steady;       // current stream goes out with no gaps
  int   burst_left;
  int   bytes_sent;
  int   quiet;
  logic [7:0] strm[$];  // bytes of the stream being built

  annexb_nal_boundary_finder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  anbf_result_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .units_waiting (units_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake shows up as a long run of cycles with no beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("annexb_nal_boundary_finder_tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Receiver: switches at random among stall patterns (always ready, coin
  // flip, 3 of 4, mostly stalled). A long hold-off request from the
  // sender overrides the pattern so the result queue backs up into in_ready.
  initial begin : rx_side
    int cyc;
    int mode;
    bit hold_done;
    cyc       = 0;
    mode      = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else begin
        if (cyc % 48 == 0) mode = $urandom_range(0, 3);
        cyc++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (cyc % 4 != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Payload bytes lean toward 00 and 01 so that stray start codes and
  // near misses (00 00 xx, 00 01) show up inside units.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h00;
      3:       return 8'h01;
      4:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_start_code(input bit four);
    if (four) strm.push_back(8'h00);
    strm.push_back(8'h00);
    strm.push_back(8'h00);
    strm.push_back(8'h01);
  endfunction

  // Mostly well-formed streams (lead code, units, separators, sometimes a
  // trailing start code); the rest break the lead code or are pure noise.
  function automatic void build_random_stream();
    int kind;
    int nunits;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 78) begin
      add_start_code(1'($urandom_range(0, 1)));
      nunits = $urandom_range(1, 5);
      for (int u = 0; u < nunits; u++) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
        repeat (len) strm.push_back(payload_byte());
        if (u < nunits - 1) add_start_code(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 4) == 0) add_start_code(1'($urandom_range(0, 1)));
    end else if (kind < 90) begin
      case ($urandom_range(0, 4))
        0: strm = '{8'h00, 8'h01};
        1: strm = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
        2: strm = '{8'h00, 8'h00, 8'($urandom_range(2, 255))};
        3: strm = '{8'h00, 8'h00, 8'h00, 8'($urandom_range(2, 255))};
        default: strm = '{8'($urandom_range(1, 255))};
      endcase
      repeat ($urandom_range(0, 6)) strm.push_back(payload_byte());
    end else begin
      repeat ($urandom_range(1, 8)) strm.push_back(payload_byte());
    end
  endfunction

  // One byte beat. Entered and left at a falling edge; valid stays up
  // across a burst, gaps only open between bursts.
  task automatic send_beat(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = 0;
      if (!steady) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: gap = 0;
          4, 5, 6:    gap = $urandom_range(1, 3);
          7, 8:       gap = $urandom_range(4, 9);
          default:    gap = $urandom_range(10, 30);
        endcase
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: fin};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_stream();
    foreach (strm[i]) send_beat(strm[i], i == strm.size() - 1);
    strm.delete();
  endtask

  // Sender pause: hold off until every predicted unit has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (units_waiting != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  initial begin : stimulus
    int stream_no;
    int rand_start;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    long_hold  = 1'b0;
    steady     = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 4-byte lead, then 00 00 01 right away: the lead's zeros must not
    // count, so the first unit is empty; later a short code, final unit.
    strm = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01,
             8'hAA, 8'h00, 8'h00, 8'h01, 8'hCC};
    send_stream();
    // 3-byte lead, long code inside the payload ending on the last byte:
    // closed unit plus an empty final unit.
    strm = '{8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01};
    send_stream();
    // Missing lead code, single byte stream.
    strm = '{8'h07};
    send_stream();
    // Stream ends before its lead code is complete.
    strm = '{8'h00, 8'h00};
    send_stream();
    // Lead code on the final byte: one empty unit at offset 3.
    strm = '{8'h00, 8'h00, 8'h01};
    send_stream();
    drain_results();

    stream_no  = 0;
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      stream_no++;
      if (stream_no == 20) begin
        // Dense units while the receiver holds off: the result queue
        // fills and in_ready must drop while valid stays up.
        drain_results();
        add_start_code(1'b0);
        repeat (14) begin
          strm.push_back(payload_byte());
          add_start_code(1'b0);
        end
        strm.push_back(8'h42);
        steady    = 1'b1;
        long_hold = 1'b1;
      end else begin
        build_random_stream();
        steady = ($urandom_range(0, 3) == 0);
      end
      send_stream();
      if (stream_no % 25 == 0) drain_results();
    end
    drain_results();

    if (mismatches == 0 && units_waiting == 0) begin
      $display("annexb_nal_boundary_finder_tb: clean");
    end else begin
      $display("annexb_nal_boundary_finder_tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/anbf_pkg.sv
hdl/anbf_out_fifo.sv
hdl/annexb_nal_boundary_finder.sv
verif/anbf_result_checker.sv
verif/annexb_nal_boundary_finder_tb.sv
